@@ src/cfr_pkg.sv @@
// shared widths, header codes, controller states and command/status bundles
`default_nettype none

package cfr_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;

    localparam int LENGTH_LIMIT = 50;

    localparam logic [BYTE_W-1:0] HEADER_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND = 8'hAF;
    localparam logic [BYTE_W-1:0] FUNC_BOUND    = 8'hF1;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_HEAD1   = 8'b0000_0010,
        S_HEAD2   = 8'b0000_0100,
        S_FUNC    = 8'b0000_1000,
        S_DATA    = 8'b0001_0000,
        S_SUM     = 8'b0010_0000,
        S_EMIT_RD = 8'b0100_0000,
        S_EMIT_LD = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic sum_load;
        logic sum_add;
        logic func_load;
        logic len_load;
        logic store_wr;
        logic emit_start;
        logic rd_en;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_first;
        logic is_second;
        logic func_ok;
        logic len_ok;
        logic rem_zero;
        logic rem_one;
        logic sum_match;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ src/cfr_if.sv @@
// valid/ready channels for received bytes and for payload results
`default_nettype none

interface cfr_rx_if;
    logic                       valid;
    logic                       ready;
    logic [cfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_res_if;
    logic                       valid;
    logic                       ready;
    logic [cfr_pkg::BYTE_W-1:0] func_code;
    logic [cfr_pkg::CNT_W-1:0]  payload_len;
    logic [cfr_pkg::CNT_W-1:0]  byte_index;
    logic [cfr_pkg::BYTE_W-1:0] payload_byte;
    logic                       last;

    modport source (output valid, output func_code, output payload_len, output byte_index,
                    output payload_byte, output last, input ready);
    modport sink   (input valid, input func_code, input payload_len, input byte_index,
                    input payload_byte, input last, output ready);
endinterface

`default_nettype wire

@@ src/cfr_ctrl.sv @@
// frame parser state machine, drives datapath commands
`default_nettype none

module cfr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rx_valid,
    output logic               rx_ready,
    input  wire cfr_pkg::sts_t sts,
    output cfr_pkg::cmd_t      cmd
);

    cfr_pkg::state_t state_reg;
    cfr_pkg::state_t state_next;
    logic            acc;

    assign rx_ready = !(state_reg inside {cfr_pkg::S_EMIT_RD, cfr_pkg::S_EMIT_LD});
    assign acc      = rx_valid && rx_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            cfr_pkg::S_IDLE:
            begin
                if (acc && sts.is_first)
                begin
                    cmd.sum_load = 1'b1;
                    state_next   = cfr_pkg::S_HEAD1;
                end
            end
            cfr_pkg::S_HEAD1:
            begin
                if (acc)
                begin
                    if (sts.is_second)
                    begin
                        cmd.sum_add = 1'b1;
                        state_next  = cfr_pkg::S_HEAD2;
                    end
                    else
                    begin
                        state_next = cfr_pkg::S_IDLE;
                    end
                end
            end
            cfr_pkg::S_HEAD2:
            begin
                if (acc)
                begin
                    if (sts.func_ok)
                    begin
                        cmd.func_load = 1'b1;
                        cmd.sum_add   = 1'b1;
                        state_next    = cfr_pkg::S_FUNC;
                    end
                    else
                    begin
                        state_next = cfr_pkg::S_IDLE;
                    end
                end
            end
            cfr_pkg::S_FUNC:
            begin
                if (acc)
                begin
                    if (sts.len_ok)
                    begin
                        cmd.len_load = 1'b1;
                        cmd.sum_add  = 1'b1;
                        state_next   = cfr_pkg::S_DATA;
                    end
                    else
                    begin
                        state_next = cfr_pkg::S_IDLE;
                    end
                end
            end
            cfr_pkg::S_DATA:
            begin
                if (acc)
                begin
                    // zero-length frame: the next byte just drops the frame
                    if (!sts.rem_zero)
                    begin
                        cmd.store_wr = 1'b1;
                        cmd.sum_add  = 1'b1;
                        if (sts.rem_one)
                        begin
                            state_next = cfr_pkg::S_SUM;
                        end
                    end
                    else
                    begin
                        state_next = cfr_pkg::S_IDLE;
                    end
                end
            end
            cfr_pkg::S_SUM:
            begin
                if (acc)
                begin
                    if (sts.sum_match)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = cfr_pkg::S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = cfr_pkg::S_IDLE;
                    end
                end
            end
            cfr_pkg::S_EMIT_RD:
            begin
                // read only once the output register frees up
                if (sts.out_free)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = cfr_pkg::S_EMIT_LD;
                end
            end
            cfr_pkg::S_EMIT_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = sts.emit_last ? cfr_pkg::S_IDLE : cfr_pkg::S_EMIT_RD;
            end
            default:
            begin
                state_next = cfr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ src/cfr_dpath.sv @@
// byte compares, checksum, counters, payload memory and result register
`default_nettype none

module cfr_dpath #(
    parameter int LENGTH_LIMIT = cfr_pkg::LENGTH_LIMIT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [cfr_pkg::BYTE_W-1:0] rx_byte,
    input  wire cfr_pkg::cmd_t              cmd,
    output cfr_pkg::sts_t                   sts,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic [cfr_pkg::BYTE_W-1:0]      func_code,
    output logic [cfr_pkg::CNT_W-1:0]       payload_len,
    output logic [cfr_pkg::CNT_W-1:0]       byte_index,
    output logic [cfr_pkg::BYTE_W-1:0]      payload_byte,
    output logic                            last
);

    localparam int STORE_DEPTH = LENGTH_LIMIT - 1;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [cfr_pkg::BYTE_W-1:0] LEN_BOUND = cfr_pkg::BYTE_W'(LENGTH_LIMIT);
    localparam int CW = cfr_pkg::CNT_W;

    logic [cfr_pkg::BYTE_W-1:0] sum_reg,  sum_next;
    logic [cfr_pkg::BYTE_W-1:0] func_reg, func_next;
    logic [CW-1:0]              len_reg,  len_next;
    logic [CW-1:0]              rem_reg,  rem_next;
    logic [CW-1:0]              rcv_reg,  rcv_next;
    logic [CW-1:0]              idx_reg,  idx_next;
    logic                       out_valid_reg, out_valid_next;

    logic [cfr_pkg::BYTE_W-1:0] mem [STORE_DEPTH];
    logic [cfr_pkg::BYTE_W-1:0] rd_data_reg;

    logic [cfr_pkg::BYTE_W-1:0] func_out_reg;
    logic [CW-1:0]              len_out_reg;
    logic [CW-1:0]              idx_out_reg;
    logic [cfr_pkg::BYTE_W-1:0] byte_out_reg;
    logic                       last_out_reg;

    always_comb
    begin
        sts.is_first  = (rx_byte == cfr_pkg::HEADER_FIRST);
        sts.is_second = (rx_byte == cfr_pkg::HEADER_SECOND);
        sts.func_ok   = (rx_byte != '0) && (rx_byte < cfr_pkg::FUNC_BOUND);
        sts.len_ok    = (rx_byte < LEN_BOUND);
        sts.rem_zero  = (rem_reg == '0);
        sts.rem_one   = (rem_reg == CW'(1));
        sts.sum_match = (rx_byte == sum_reg);
        sts.emit_last = ((idx_reg + CW'(1)) == rcv_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        sum_next       = sum_reg;
        func_next      = func_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        rcv_next       = rcv_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.sum_load)
        begin
            sum_next = rx_byte;
        end
        if (cmd.sum_add)
        begin
            sum_next = sum_reg + rx_byte;
        end
        if (cmd.func_load)
        begin
            func_next = rx_byte;
        end
        if (cmd.len_load)
        begin
            len_next = rx_byte[CW-1:0];
            rem_next = rx_byte[CW-1:0];
            rcv_next = '0;
        end
        if (cmd.store_wr)
        begin
            rcv_next = rcv_reg + CW'(1);
            rem_next = rem_reg - CW'(1);
        end
        if (cmd.emit_start)
        begin
            idx_next = '0;
        end
        if (cmd.out_load)
        begin
            idx_next       = idx_reg + CW'(1);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            func_reg      <= '0;
            len_reg       <= '0;
            rem_reg       <= '0;
            rcv_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            func_reg      <= func_next;
            len_reg       <= len_next;
            rem_reg       <= rem_next;
            rcv_reg       <= rcv_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            mem[rcv_reg[AW-1:0]] <= rx_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            func_out_reg <= func_reg;
            len_out_reg  <= len_reg;
            idx_out_reg  <= idx_reg;
            byte_out_reg <= rd_data_reg;
            last_out_reg <= sts.emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign func_code    = func_out_reg;
    assign payload_len  = len_out_reg;
    assign byte_index   = idx_out_reg;
    assign payload_byte = byte_out_reg;
    assign last         = last_out_reg;

    // result register never overwritten while still holding an item
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg)
        else $error("result register overwritten");

    // payload writes stay inside the store
    a_store_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_wr |-> (rcv_reg < CW'(STORE_DEPTH)))
        else $error("payload write beyond store");

    // a matched frame holds exactly its declared number of payload bytes
    a_full_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_start |-> (rcv_reg == len_reg) && (len_reg != '0))
        else $error("emitting a frame with wrong byte count");

    // emitted index stays below the frame length
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (idx_reg < len_reg))
        else $error("emit index past frame length");

endmodule

`default_nettype wire

@@ src/checksummed_frame_receiver_core.sv @@
// top level: frame parser controller joined to its datapath
//
//  channel | role    | payload
//  --------+---------+-----------------------------------------------------
//  rx      | sink    | rx_byte
//  res     | source  | func_code, payload_len, byte_index, payload_byte, last
//
// one received byte is taken per cycle while parsing
// a good checksum byte starts a burst of payload_len results, each one memory
// read and then one load of the result register; rx is held off during the burst
// and reopens once the last result is in the result register
// a stalled res side stalls the burst only; reset clears parser and counters,
// the payload memory itself needs no clearing
`default_nettype none

module checksummed_frame_receiver_core #(
    parameter int LENGTH_LIMIT = cfr_pkg::LENGTH_LIMIT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cfr_rx_if.sink     rx,
    cfr_res_if.source  res
);

    cfr_pkg::cmd_t cmd;
    cfr_pkg::sts_t sts;

    cfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfr_dpath #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx.rx_byte),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (res.ready),
        .out_valid    (res.valid),
        .func_code    (res.func_code),
        .payload_len  (res.payload_len),
        .byte_index   (res.byte_index),
        .payload_byte (res.payload_byte),
        .last         (res.last)
    );

endmodule

`default_nettype wire
